// File: rtl/core/crif_pkg.sv
// Package for the coverage repeat interval finder.
// Holds the sequencer state type, the stored alignment row type and the fixed constants.
// No dependencies.
`default_nettype none
package crif_pkg;

   localparam int MAX_ALIGNS_DEF = 64;
   localparam int RESULT_CAP     = 64;
   localparam int PEEL           = 300;
   localparam int GAP_SLACK      = 1000;
   localparam int HILL_TINY      = 3;
   localparam int HILL_MIN       = 10;
   localparam int OVER_MAX       = 20;
   localparam logic [7:0] THR_RESET = 8'd10;

   typedef struct packed {
      logic [19:0] a_begin;
      logic [19:0] a_end;
      logic [19:0] b_end;
      logic [23:0] partner_id;
      logic        complemented;
   } align_row_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_M_RD, S_M_CHK, S_INS,
      S_B_RD, S_B_W1, S_B_W2,
      S_K_RD, S_K_LD, S_I_RD, S_I_CMP, S_I_PUT,
      S_W_RD, S_W_PROC,
      S_F_INIT, S_F_R0, S_F_R1, S_F_R2, S_F_R3, S_F_DEC, S_F_W2, S_F_DONE,
      S_E_R0, S_E_R1, S_E_R2, S_E_OUT,
      S_NONE
   } state_type;

endpackage
`default_nettype wire

// File: rtl/core/coverage_repeat_interval_finder_unit.sv
// Top level of the coverage repeat interval finder.
// One sequencer over three memories, each with one read and one write port; depends on crif_pkg.
`default_nettype none
// The block takes the alignments of one read as requests, one per request, and
// answers each read with its high-coverage intervals. A request that is not
// the last of its read produces no response; it runs the merge search over the
// stored alignments (newest to oldest, stopping at the first entry with another
// partner or strand). On the last request the block builds the begin and end
// events, insertion-sorts them in the event memory, sweeps them, folds shallow
// troughs and then emits one response per interval when the response side does
// not stall. All of this runs through one read and one write port per memory.
// req_stall stays high for the whole of that work. An empty read, or a read
// with no interval, gives a single response with none_found set.
// coverage_threshold is to be written on the csr channel while the block is
// idle; the block itself does not enforce this.
module coverage_repeat_interval_finder_unit #(
   parameter int MAX_ALIGNS = crif_pkg::MAX_ALIGNS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [19:0]        req_a_begin,
   input  wire logic [19:0]        req_a_end,
   input  wire logic [23:0]        req_partner_id,
   input  wire logic [19:0]        req_b_begin,
   input  wire logic [19:0]        req_b_end,
   input  wire logic               req_complemented,
   input  wire logic               req_last_of_read,
   input  wire logic               req_empty_read,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [21:0]      rsp_interval_begin,
   output logic signed [21:0]      rsp_interval_end,
   output logic                    rsp_none_found,
   output logic                    rsp_overflow,
   output logic                    rsp_last,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [7:0]         csr_coverage_threshold
);

   // Index widths: AW addresses the alignment store, EW the event and interval
   // stores (twice as deep), NW counts up to the event store depth.
   localparam int AW  = (MAX_ALIGNS > 1) ? $clog2(MAX_ALIGNS) : 1;
   localparam int EW  = AW + 1;
   localparam int NW  = EW + 1;
   localparam int EVD = 2 * MAX_ALIGNS;
   // Depth values are signed: coverage can dip below zero when an end event
   // sorts ahead of its own begin, and the threshold reaches 255.
   localparam int CW  = $clog2(MAX_ALIGNS + 1) + 1;
   localparam int DW  = (CW > 9) ? CW : 9;

   // Memories.
   crif_pkg::align_row_type align_mem [MAX_ALIGNS];
   logic signed [22:0]      ev_mem    [EVD];
   logic signed [22:0]      ivb_mem   [EVD];
   logic signed [DW-1:0]    ivd_mem   [EVD];

   logic                    al_we;
   logic [AW-1:0]           al_waddr, al_raddr;
   crif_pkg::align_row_type al_wdata, al_rd_ff;
   logic                    ev_we;
   logic [EW-1:0]           ev_waddr, ev_raddr;
   logic signed [22:0]      ev_wdata, ev_rd_ff;
   logic                    iv_we;
   logic [EW-1:0]           iv_waddr, iv_raddr;
   logic signed [22:0]      iv_wb, ivb_rd_ff;
   logic signed [DW-1:0]    iv_wd, ivd_rd_ff;

   always_ff @(posedge clock) begin
      if (al_we) begin
         align_mem[al_waddr] <= al_wdata;
      end
      al_rd_ff <= align_mem[al_raddr];
   end

   always_ff @(posedge clock) begin
      if (ev_we) begin
         ev_mem[ev_waddr] <= ev_wdata;
      end
      ev_rd_ff <= ev_mem[ev_raddr];
   end

   always_ff @(posedge clock) begin
      if (iv_we) begin
         ivb_mem[iv_waddr] <= iv_wb;
         ivd_mem[iv_waddr] <= iv_wd;
      end
      ivb_rd_ff <= ivb_mem[iv_raddr];
      ivd_rd_ff <= ivd_mem[iv_raddr];
   end

   // Control state.
   crif_pkg::state_type state_ff, state_in;
   logic [7:0]          thr_ff, thr_in;
   logic [NW-1:0]       cnt_ff, cnt_in;
   logic                drop_ff, drop_in;
   logic [NW-1:0]       i_ff, i_in;
   logic [NW-1:0]       p_ff, p_in;
   logic [NW-1:0]       n_ff, n_in;
   logic [NW-1:0]       nt_ff, nt_in;
   logic [NW-1:0]       nres_ff, nres_in;
   logic                ovf_ff, ovf_in;
   logic signed [DW-1:0] cov_ff, cov_in, mn_ff, mn_in, mx_ff, mx_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   crif_pkg::align_row_type in_row_ff, in_row_in;
   logic [19:0]         in_bb_ff, in_bb_in;
   logic                in_last_ff, in_last_in;
   logic signed [22:0]  key_ff, key_in;
   logic signed [22:0]  fa_b_ff, fa_b_in, fb_b_ff, fb_b_in, fc_b_ff, fc_b_in;
   logic signed [DW-1:0] fa_d_ff, fa_d_in, fb_d_ff, fb_d_in, fc_d_ff, fc_d_in;
   logic signed [21:0]  rsp_begin_ff, rsp_begin_in, rsp_end_ff, rsp_end_in;
   logic                rsp_none_ff, rsp_none_in, rsp_ovf_ff, rsp_ovf_in;
   logic                rsp_last_ff, rsp_last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crif_pkg::S_IDLE;
         thr_ff       <= crif_pkg::THR_RESET;
         cnt_ff       <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         cnt_ff       <= cnt_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      p_ff         <= p_in;
      n_ff         <= n_in;
      nt_ff        <= nt_in;
      nres_ff      <= nres_in;
      ovf_ff       <= ovf_in;
      cov_ff       <= cov_in;
      mn_ff        <= mn_in;
      mx_ff        <= mx_in;
      in_row_ff    <= in_row_in;
      in_bb_ff     <= in_bb_in;
      in_last_ff   <= in_last_in;
      key_ff       <= key_in;
      fa_b_ff      <= fa_b_in;
      fb_b_ff      <= fb_b_in;
      fc_b_ff      <= fc_b_in;
      fa_d_ff      <= fa_d_in;
      fb_d_ff      <= fb_d_in;
      fc_d_ff      <= fc_d_in;
      rsp_begin_ff <= rsp_begin_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_none_ff  <= rsp_none_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_stall          = (state_ff != crif_pkg::S_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_interval_begin = rsp_begin_ff;
   assign rsp_interval_end   = rsp_end_ff;
   assign rsp_none_found     = rsp_none_ff;
   assign rsp_overflow       = rsp_ovf_ff;
   assign rsp_last           = rsp_last_ff;

   // The merge test of a new alignment against one stored row.
   logic               near;
   logic signed [21:0] agap, bgap;
   logic signed [22:0] gdif, gmag;
   logic [25:0]        five;
   logic signed [25:0] rhs;
   logic               gap_ok;
   always_comb begin
      near   = ({1'b0, al_rd_ff.a_end} < ({1'b0, in_row_ff.a_begin} + 21'(crif_pkg::PEEL)));
      agap   = $signed({2'b0, in_row_ff.a_begin}) - $signed({2'b0, al_rd_ff.a_end});
      bgap   = $signed({2'b0, in_bb_ff}) - $signed({2'b0, al_rd_ff.b_end});
      gdif   = 23'(agap) - 23'(bgap);
      gmag   = (gdif < 0) ? -gdif : gdif;
      five   = {1'b0, gmag[21:0], 2'b0} + {4'b0, gmag[21:0]};
      rhs    = 26'(agap) + 26'(bgap) + 26'(crif_pkg::GAP_SLACK);
      gap_ok = ($signed(five) < rhs);
   end

   // Event construction from one stored row.
   logic [20:0]        ev_b;
   logic signed [21:0] ev_e;
   logic [20:0]        ev_mid;
   always_comb begin
      ev_b   = {1'b0, al_rd_ff.a_begin} + 21'(crif_pkg::PEEL);
      ev_e   = $signed({2'b0, al_rd_ff.a_end}) - 22'(crif_pkg::PEEL);
      ev_mid = ({1'b0, al_rd_ff.a_begin} + {1'b0, al_rd_ff.a_end}) >> 1;
   end

   // Sweep and fold arithmetic.
   logic signed [22:0]   pos;
   logic signed [DW-1:0] thr_s, cov_up, cov_dn;
   logic signed [DW:0]   deep1, deep2, deep;
   logic signed [23:0]   over;
   logic                 fold;
   logic                 out_free;
   logic [NW-1:0]        nfin;
   always_comb begin
      pos    = ev_rd_ff >>> 1;
      thr_s  = $signed({{(DW - 8){1'b0}}, thr_ff});
      cov_up = cov_ff + DW'(1);
      cov_dn = cov_ff - DW'(1);
      deep1  = (DW + 1)'(fa_d_ff) - (DW + 1)'(fb_d_ff);
      deep2  = (DW + 1)'(fc_d_ff) - (DW + 1)'(fb_d_ff);
      deep   = (deep2 < deep1) ? deep2 : deep1;
      over   = 24'(fa_b_ff) - 24'(fb_b_ff);
      fold   = (deep <= (DW + 1)'(crif_pkg::HILL_TINY)) ||
               ((deep < (DW + 1)'(crif_pkg::HILL_MIN)) && (over > 24'(crif_pkg::OVER_MAX)));
      out_free = !rsp_valid_ff || !rsp_stall;
      nfin   = (nt_ff != '0) ? p_ff : '0;
   end

   always_comb begin
      state_in     = state_ff;
      thr_in       = thr_ff;
      cnt_in       = cnt_ff;
      drop_in      = drop_ff;
      i_in         = i_ff;
      p_in         = p_ff;
      n_in         = n_ff;
      nt_in        = nt_ff;
      nres_in      = nres_ff;
      ovf_in       = ovf_ff;
      cov_in       = cov_ff;
      mn_in        = mn_ff;
      mx_in        = mx_ff;
      in_row_in    = in_row_ff;
      in_bb_in     = in_bb_ff;
      in_last_in   = in_last_ff;
      key_in       = key_ff;
      fa_b_in      = fa_b_ff;
      fb_b_in      = fb_b_ff;
      fc_b_in      = fc_b_ff;
      fa_d_in      = fa_d_ff;
      fb_d_in      = fb_d_ff;
      fc_d_in      = fc_d_ff;
      rsp_begin_in = rsp_begin_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_none_in  = rsp_none_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      al_we    = 1'b0;
      al_waddr = p_ff[AW-1:0];
      al_wdata = in_row_ff;
      al_raddr = p_ff[AW-1:0];
      ev_we    = 1'b0;
      ev_waddr = p_ff[EW-1:0];
      ev_wdata = key_ff;
      ev_raddr = i_ff[EW-1:0];
      iv_we    = 1'b0;
      iv_waddr = nt_ff[EW-1:0];
      iv_wb    = fb_b_ff;
      iv_wd    = fb_d_ff;
      iv_raddr = i_ff[EW-1:0];

      if (csr_valid) begin
         thr_in = csr_coverage_threshold;
      end

      unique case (state_ff)
         crif_pkg::S_IDLE: begin
            if (req_valid) begin
               in_row_in.a_begin      = req_a_begin;
               in_row_in.a_end        = req_a_end;
               in_row_in.b_end        = req_b_end;
               in_row_in.partner_id   = req_partner_id;
               in_row_in.complemented = req_complemented;
               in_bb_in   = req_b_begin;
               in_last_in = req_last_of_read;
               p_in       = cnt_ff;
               if (req_empty_read) begin
                  ovf_in   = drop_ff;
                  cnt_in   = '0;
                  drop_in  = 1'b0;
                  state_in = crif_pkg::S_NONE;
               end else if (cnt_ff == '0) begin
                  state_in = crif_pkg::S_INS;
               end else begin
                  state_in = crif_pkg::S_M_RD;
               end
            end
         end

         // Merge search, newest entry first.
         crif_pkg::S_M_RD: begin
            al_raddr = AW'(p_ff - NW'(1));
            state_in = crif_pkg::S_M_CHK;
         end

         crif_pkg::S_M_CHK: begin
            if (al_rd_ff.partner_id != in_row_ff.partner_id ||
                al_rd_ff.complemented != in_row_ff.complemented) begin
               state_in = crif_pkg::S_INS;
            end else if (near && gap_ok) begin
               al_we    = 1'b1;
               al_waddr = AW'(p_ff - NW'(1));
               al_wdata = al_rd_ff;
               if (in_row_ff.a_end > al_rd_ff.a_end) begin
                  al_wdata.a_end = in_row_ff.a_end;
               end
               if (in_row_ff.b_end > al_rd_ff.b_end) begin
                  al_wdata.b_end = in_row_ff.b_end;
               end
               i_in     = '0;
               state_in = in_last_ff ? crif_pkg::S_B_RD : crif_pkg::S_IDLE;
            end else if (p_ff == NW'(1)) begin
               state_in = crif_pkg::S_INS;
            end else begin
               p_in     = p_ff - NW'(1);
               state_in = crif_pkg::S_M_RD;
            end
         end

         crif_pkg::S_INS: begin
            if (cnt_ff < NW'(MAX_ALIGNS)) begin
               al_we    = 1'b1;
               al_waddr = cnt_ff[AW-1:0];
               al_wdata = in_row_ff;
               cnt_in   = cnt_ff + NW'(1);
            end else begin
               drop_in = 1'b1;
            end
            i_in     = '0;
            state_in = in_last_ff ? crif_pkg::S_B_RD : crif_pkg::S_IDLE;
         end

         // Build begin and end events, two per stored span.
         crif_pkg::S_B_RD: begin
            al_raddr = i_ff[AW-1:0];
            if (i_ff == cnt_ff) begin
               n_in     = {cnt_ff[NW-2:0], 1'b0};
               i_in     = NW'(1);
               state_in = crif_pkg::S_K_RD;
            end else begin
               state_in = crif_pkg::S_B_W1;
            end
         end

         crif_pkg::S_B_W1: begin
            ev_we    = 1'b1;
            ev_waddr = {i_ff[AW-1:0], 1'b0};
            if (ev_e < $signed({1'b0, ev_b})) begin
               ev_wdata = $signed({1'b0, ev_mid, 1'b1});
               key_in   = $signed({1'b0, ev_mid, 1'b0});
            end else begin
               ev_wdata = $signed({1'b0, ev_b, 1'b1});
               key_in   = $signed({ev_e, 1'b0});
            end
            state_in = crif_pkg::S_B_W2;
         end

         crif_pkg::S_B_W2: begin
            ev_we    = 1'b1;
            ev_waddr = {i_ff[AW-1:0], 1'b1};
            ev_wdata = key_ff;
            i_in     = i_ff + NW'(1);
            state_in = crif_pkg::S_B_RD;
         end

         // Insertion sort in place.
         crif_pkg::S_K_RD: begin
            ev_raddr = i_ff[EW-1:0];
            if (i_ff >= n_ff) begin
               i_in     = '0;
               cov_in   = '0;
               mn_in    = '0;
               mx_in    = '0;
               nt_in    = '0;
               state_in = crif_pkg::S_W_RD;
            end else begin
               state_in = crif_pkg::S_K_LD;
            end
         end

         crif_pkg::S_K_LD: begin
            key_in   = ev_rd_ff;
            p_in     = i_ff;
            state_in = crif_pkg::S_I_RD;
         end

         crif_pkg::S_I_RD: begin
            ev_raddr = EW'(p_ff - NW'(1));
            state_in = crif_pkg::S_I_CMP;
         end

         crif_pkg::S_I_CMP: begin
            if (ev_rd_ff > key_ff) begin
               ev_we    = 1'b1;
               ev_waddr = p_ff[EW-1:0];
               ev_wdata = ev_rd_ff;
               p_in     = p_ff - NW'(1);
               state_in = (p_ff == NW'(1)) ? crif_pkg::S_I_PUT : crif_pkg::S_I_RD;
            end else begin
               state_in = crif_pkg::S_I_PUT;
            end
         end

         crif_pkg::S_I_PUT: begin
            ev_we    = 1'b1;
            ev_waddr = p_ff[EW-1:0];
            ev_wdata = key_ff;
            i_in     = i_ff + NW'(1);
            state_in = crif_pkg::S_K_RD;
         end

         // Coverage sweep over the sorted events.
         crif_pkg::S_W_RD: begin
            ev_raddr = i_ff[EW-1:0];
            state_in = (i_ff == n_ff) ? crif_pkg::S_F_INIT : crif_pkg::S_W_PROC;
         end

         crif_pkg::S_W_PROC: begin
            iv_waddr = nt_ff[EW-1:0];
            if (ev_rd_ff[0]) begin
               cov_in = cov_up;
               if (cov_up > mx_ff) begin
                  mx_in = mx_ff + DW'(1);
               end
               if (cov_up == thr_s) begin
                  iv_we = 1'b1;
                  iv_wb = pos - 23'(crif_pkg::PEEL);
                  iv_wd = mn_ff;
                  nt_in = nt_ff + NW'(1);
                  mx_in = thr_s;
               end
            end else begin
               cov_in = cov_dn;
               if (cov_ff == thr_s) begin
                  iv_we = 1'b1;
                  iv_wb = pos + 23'(crif_pkg::PEEL);
                  iv_wd = mx_ff;
                  nt_in = nt_ff + NW'(1);
                  mn_in = (cov_dn < thr_s) ? cov_dn : thr_s;
               end else if (cov_dn < mn_ff) begin
                  mn_in = cov_dn;
               end
            end
            i_in     = i_ff + NW'(1);
            state_in = crif_pkg::S_W_RD;
         end

         // Fold neighbors across shallow troughs; p holds the write cursor.
         crif_pkg::S_F_INIT: begin
            nt_in    = {nt_ff[NW-1:1], 1'b0};
            i_in     = NW'(2);
            p_in     = NW'(2);
            state_in = crif_pkg::S_F_R0;
         end

         crif_pkg::S_F_R0: begin
            iv_raddr = EW'(i_ff - NW'(1));
            state_in = ((i_ff + NW'(1)) < nt_ff) ? crif_pkg::S_F_R1 : crif_pkg::S_F_DONE;
         end

         crif_pkg::S_F_R1: begin
            iv_raddr = i_ff[EW-1:0];
            fa_b_in  = ivb_rd_ff;
            fa_d_in  = ivd_rd_ff;
            state_in = crif_pkg::S_F_R2;
         end

         crif_pkg::S_F_R2: begin
            iv_raddr = EW'(i_ff + NW'(1));
            fb_b_in  = ivb_rd_ff;
            fb_d_in  = ivd_rd_ff;
            state_in = crif_pkg::S_F_R3;
         end

         crif_pkg::S_F_R3: begin
            iv_raddr = EW'(p_ff - NW'(1));
            fc_b_in  = ivb_rd_ff;
            fc_d_in  = ivd_rd_ff;
            state_in = crif_pkg::S_F_DEC;
         end

         crif_pkg::S_F_DEC: begin
            iv_we = 1'b1;
            if (fold) begin
               iv_waddr = EW'(p_ff - NW'(1));
               iv_wb    = fc_b_ff;
               iv_wd    = (fc_d_ff > ivd_rd_ff) ? fc_d_ff : ivd_rd_ff;
               i_in     = i_ff + NW'(2);
               state_in = crif_pkg::S_F_R0;
            end else begin
               iv_waddr = p_ff[EW-1:0];
               iv_wb    = fb_b_ff;
               iv_wd    = fb_d_ff;
               state_in = crif_pkg::S_F_W2;
            end
         end

         crif_pkg::S_F_W2: begin
            iv_we    = 1'b1;
            iv_waddr = EW'(p_ff + NW'(1));
            iv_wb    = fc_b_ff;
            iv_wd    = fc_d_ff;
            p_in     = p_ff + NW'(2);
            i_in     = i_ff + NW'(2);
            state_in = crif_pkg::S_F_R0;
         end

         crif_pkg::S_F_DONE: begin
            nres_in = nfin >> 1;
            ovf_in  = drop_ff;
            if (int'(nfin >> 1) > crif_pkg::RESULT_CAP) begin
               nres_in = NW'(crif_pkg::RESULT_CAP);
               ovf_in  = 1'b1;
            end
            cnt_in   = '0;
            drop_in  = 1'b0;
            i_in     = '0;
            state_in = (nfin < NW'(2)) ? crif_pkg::S_NONE : crif_pkg::S_E_R0;
         end

         // Emit intervals; i counts responses.
         crif_pkg::S_E_R0: begin
            iv_raddr = {i_ff[AW-1:0], 1'b0};
            state_in = crif_pkg::S_E_R1;
         end

         crif_pkg::S_E_R1: begin
            iv_raddr = {i_ff[AW-1:0], 1'b1};
            fa_b_in  = ivb_rd_ff;
            state_in = crif_pkg::S_E_R2;
         end

         crif_pkg::S_E_R2: begin
            fb_b_in  = ivb_rd_ff;
            state_in = crif_pkg::S_E_OUT;
         end

         crif_pkg::S_E_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_begin_in = fa_b_ff[21:0];
               rsp_end_in   = fb_b_ff[21:0];
               rsp_none_in  = 1'b0;
               rsp_ovf_in   = ovf_ff;
               rsp_last_in  = ((i_ff + NW'(1)) == nres_ff);
               i_in         = i_ff + NW'(1);
               state_in     = ((i_ff + NW'(1)) == nres_ff) ? crif_pkg::S_IDLE
                                                            : crif_pkg::S_E_R0;
            end
         end

         crif_pkg::S_NONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_begin_in = '0;
               rsp_end_in   = '0;
               rsp_none_in  = 1'b1;
               rsp_ovf_in   = ovf_ff;
               rsp_last_in  = 1'b1;
               state_in     = crif_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = crif_pkg::S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/core/crif_checker.sv
// Port-level checker for the coverage repeat interval finder, with its bind.
// Depends on coverage_repeat_interval_finder_unit.
`default_nettype none
module crif_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic [19:0]        req_a_begin,
   input wire logic [19:0]        req_a_end,
   input wire logic [23:0]        req_partner_id,
   input wire logic [19:0]        req_b_begin,
   input wire logic [19:0]        req_b_end,
   input wire logic               req_complemented,
   input wire logic               req_last_of_read,
   input wire logic               req_empty_read,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [21:0] rsp_interval_begin,
   input wire logic signed [21:0] rsp_interval_end,
   input wire logic               rsp_none_found,
   input wire logic               rsp_overflow,
   input wire logic               rsp_last,
   input wire logic               csr_valid,
   input wire logic               csr_ready,
   input wire logic [7:0]         csr_coverage_threshold
);

   // After reset no response is pending.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_interval_begin) &&
         $stable(rsp_interval_end) && $stable(rsp_last) && $stable(rsp_none_found)))
      else $error("stalled response changed");

   // An accepted request keeps the block busy for at least the next cycle.
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken back to back");

   // A none-found response is always the last of its read.
   a_none_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_none_found) |-> rsp_last)
      else $error("none-found response not last");

   // A none-found response carries zero bounds.
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_none_found) |-> (rsp_interval_begin == 0 && rsp_interval_end == 0))
      else $error("none-found response with bounds");

endmodule

bind coverage_repeat_interval_finder_unit crif_checker u_crif_checker (.*);
`default_nettype wire
